[hw/rtl/imgconv_pkg.sv]
// Package for the 3x3 kernel convolution block: sizes, register codes,
// kernel weight table and the result entry type.
// No dependencies.
package imgconv_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_SIZE    = 3;

    localparam int PIXEL_W     = 8;
    localparam int SIZE_W      = 11;
    localparam int KSEL_W      = 2;
    localparam int POS_W       = 10;
    localparam int VALUE_W     = 12;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LINE_W      = 2 * PIXEL_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int NUM_KERNELS = 4;
    localparam int WIN_ROWS    = 3;
    localparam int NUM_TAPS    = WIN_ROWS * 3;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_SELECT = 2'd2
    } cfg_reg_t;

    typedef logic signed [1:0] weight_t;

    // weight 3*i+j: window row i (top first), column j (left first)
    localparam weight_t KERNEL_TAB [NUM_KERNELS][NUM_TAPS] = '{
        '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1},
        '{ 2'sd1, 2'sd1, 2'sd1,  2'sd0, 2'sd0, 2'sd0,  2'sd1, 2'sd1, 2'sd1},
        '{ 2'sd1, 2'sd0, 2'sd0,  2'sd0, 2'sd1, 2'sd0,  2'sd0, 2'sd0, 2'sd1},
        '{ 2'sd0, 2'sd0, 2'sd1,  2'sd0, 2'sd1, 2'sd0,  2'sd1, 2'sd0, 2'sd0}
    };

    // one entry per input transaction that yields results
    typedef struct packed {
        logic                      int_valid;
        logic                      brd_valid;
        logic                      frame_end;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [VALUE_W-1:0] sum;
        logic [PIXEL_W-1:0]        px;
    } res_entry_t;

endpackage

[hw/rtl/imgconv_if.sv]
// Handshake interfaces for the pixel input and result output channels.
// Depends on imgconv_pkg.
interface imgconv_pixel_if;
    import imgconv_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface imgconv_result_if;
    import imgconv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      from_border;
    logic                      frame_end;
    logic                      last;

    modport source (output valid, output row, output col, output value,
                    output from_border, output frame_end, output last,
                    input ready);
    modport sink   (input valid, input row, input col, input value,
                    input from_border, input frame_end, input last,
                    output ready);
    modport monitor (input valid, input ready, input row, input col,
                     input value, input from_border, input frame_end,
                     input last);
endinterface

[hw/rtl/imgconv_line_mem.sv]
// Line store memory: one word per column holding {older row, previous row}.
// Synchronous read (registered read data). Depends on imgconv_pkg.
module imgconv_line_mem (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [imgconv_pkg::COL_W-1:0]  rd_addr,
    output logic [imgconv_pkg::LINE_W-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [imgconv_pkg::COL_W-1:0]  wr_addr,
    input  logic [imgconv_pkg::LINE_W-1:0] wr_data
);
    import imgconv_pkg::*;

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/imgconv_res_fifo.sv]
// Result queue: one entry per input transaction, unpacked onto the result
// channel as one or two transactions. Depends on imgconv_pkg, imgconv_if.
module imgconv_res_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  imgconv_pkg::res_entry_t            push_entry,
    output logic [imgconv_pkg::FIFO_CNT_W-1:0] level,
    imgconv_result_if.source                   results
);
    import imgconv_pkg::*;

    res_entry_t              entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    second_reg;
    logic                    second_next;
    res_entry_t              head;
    logic                    show_int;
    logic                    xfer;
    logic                    pop;

    assign head     = entries_reg[rd_ptr_reg];
    // interior result goes first, the border result of the same pixel next
    assign show_int = head.int_valid & ~second_reg;

    assign results.valid       = (count_reg != '0);
    assign results.row         = show_int ? head.row - POS_W'(1) : head.row;
    assign results.col         = show_int ? head.col - POS_W'(1) : head.col;
    assign results.value       = show_int ? head.sum
                                          : {{(VALUE_W-PIXEL_W){1'b0}}, head.px};
    assign results.from_border = ~show_int;
    assign results.last        = ~show_int | ~head.brd_valid;
    assign results.frame_end   = ~show_int & head.frame_end;

    assign xfer  = results.valid & results.ready;
    assign pop   = xfer & results.last;
    assign level = count_reg;

    always_comb
    begin
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        second_next = second_reg;
        if (pop)
        begin
            second_next = 1'b0;
        end
        else if (xfer)
        begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg  <= count_next;
            second_reg <= second_next;
        end
    end

endmodule

[hw/rtl/image_3x3_kernel_convolution.sv]
// Top level of the 3x3 kernel convolution block.
// Depends on imgconv_pkg, imgconv_if, imgconv_line_mem, imgconv_res_fifo.
//
// Usage:
//   pixels  : 8-bit grayscale pixels in raster order, one per transaction.
//   results : row, col, value, from_border, frame_end, last. An input pixel
//             yields zero, one or two result transactions; an interior
//             result for (r-1,c-1) comes before the border result for (r,c).
//   cfg_*   : write-only registers image_width (0), image_height (1),
//             kernel_select (2); write only while the block is idle. A size
//             write restarts the frame at row 0, column 0.
// Path    : an accepted pixel passes the read stage and then the result queue
//           before its first result reaches the result channel.
// Throughput: one pixel per cycle while the result queue has room. A pixel with two
//           results (right column from row 2 on, bottom row from column 2 on) needs two
//           result transactions, so a bottom row backs up the queue and holds the pixel input.
// Stall   : a four-entry result queue sits in front of the result channel;
//           pixels.ready drops once the queue plus the pixel in flight could
//           overflow it, so a stalled receiver holds the pixel input.
// Reset   : sizes return to 512 x 512, kernel 0, position 0,0 and the
//           window to zero. The line stores are not cleared; their stale
//           words are only read where the value is thrown away.
module image_3x3_kernel_convolution (
    input  logic                               clk,
    input  logic                               rst_n,
    imgconv_pixel_if.sink                      pixels,
    imgconv_result_if.source                   results,
    input  logic                               cfg_wr_en,
    input  logic [imgconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imgconv_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import imgconv_pkg::*;

    // configuration and position
    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic [KSEL_W-1:0]  kernel_select_reg;
    logic [COL_W-1:0]   col_count_reg;
    logic [ROW_W-1:0]   row_count_reg;
    logic [COL_W-1:0]   col_count_next;
    logic [ROW_W-1:0]   row_count_next;

    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic               last_col;
    logic               last_row;
    logic               accept;

    // read stage: pixel waits here while its line store word is read
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_interior_reg;
    logic               s1_border_reg;
    logic               s1_fend_reg;
    logic [KSEL_W-1:0]  s1_ksel_reg;

    logic [LINE_W-1:0]  line_rd_data;
    logic [LINE_W-1:0]  line_wr_data;

    // window: column c-1 and column c-2 of the three rows
    logic [PIXEL_W-1:0] win1_reg [WIN_ROWS];
    logic [PIXEL_W-1:0] win2_reg [WIN_ROWS];
    logic [PIXEL_W-1:0] cur      [WIN_ROWS];

    logic signed [VALUE_W-1:0] row_sum [WIN_ROWS];
    logic signed [VALUE_W-1:0] win_sum;

    logic [FIFO_CNT_W-1:0] fifo_level;
    logic                  push;
    res_entry_t            push_entry;

    function automatic logic signed [VALUE_W-1:0] weigh(
        input weight_t            wgt,
        input logic [PIXEL_W-1:0] p
    );
        logic signed [VALUE_W-1:0] ext;
        ext = {{(VALUE_W-PIXEL_W){1'b0}}, p};
        if (wgt == 2'sd1)
        begin
            return ext;
        end
        else if (wgt == -2'sd1)
        begin
            return -ext;
        end
        return '0;
    endfunction

    // ---------------- accept stage ----------------
    always_comb
    begin
        w_eff = image_width_reg;
        if (image_width_reg < SIZE_W'(MIN_SIZE))
        begin
            w_eff = SIZE_W'(MIN_SIZE);
        end
        else if (image_width_reg > SIZE_W'(MAX_WIDTH))
        begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end

        h_eff = image_height_reg;
        if (image_height_reg < SIZE_W'(MIN_SIZE))
        begin
            h_eff = SIZE_W'(MIN_SIZE);
        end
        else if (image_height_reg > SIZE_W'(MAX_HEIGHT))
        begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
    end

    assign col_cur  = (SIZE_W'(col_count_reg) >= w_eff) ? '0 : col_count_reg;
    assign row_cur  = (SIZE_W'(row_count_reg) >= h_eff) ? '0 : row_count_reg;
    assign last_col = (SIZE_W'(col_cur) == w_eff - SIZE_W'(1));
    assign last_row = (SIZE_W'(row_cur) == h_eff - SIZE_W'(1));

    // room for the in-flight pixel and this one, whatever the receiver does
    assign pixels.ready = ((FIFO_CNT_W + 1)'(fifo_level) + (FIFO_CNT_W + 1)'(s1_valid_reg))
                          < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign accept       = pixels.valid & pixels.ready;

    always_comb
    begin
        col_count_next = col_cur + COL_W'(1);
        row_count_next = row_cur;
        if (last_col)
        begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : row_cur + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= SIZE_RESET;
            image_height_reg  <= SIZE_RESET;
            kernel_select_reg <= '0;
            col_count_reg     <= '0;
            row_count_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= SIZE_W'(cfg_wr_data);
                    col_count_reg   <= '0;
                    row_count_reg   <= '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= SIZE_W'(cfg_wr_data);
                    col_count_reg    <= '0;
                    row_count_reg    <= '0;
                end
                REG_KERNEL_SELECT:
                begin
                    kernel_select_reg <= cfg_wr_data[KSEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixels.pixel;
            s1_col_reg      <= col_cur;
            s1_row_reg      <= row_cur;
            s1_interior_reg <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
            s1_border_reg   <= (row_cur == '0) || last_row || (col_cur == '0) || last_col;
            s1_fend_reg     <= last_row && last_col;
            s1_ksel_reg     <= kernel_select_reg;
        end
    end

    // ---------------- line store ----------------
    // Read at accept, write back {previous, pixel} in the next cycle. The next
    // access to the same column is at least three pixels on, so read and
    // write-back of one entry never overlap.
    assign line_wr_data = {line_rd_data[PIXEL_W-1:0], s1_px_reg};

    imgconv_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (line_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr_data)
    );

    // ---------------- window and weighted sum ----------------
    assign cur[0] = line_rd_data[LINE_W-1:PIXEL_W];
    assign cur[1] = line_rd_data[PIXEL_W-1:0];
    assign cur[2] = s1_px_reg;

    always_comb
    begin
        for (int i = 0; i < WIN_ROWS; i++)
        begin
            row_sum[i] = weigh(KERNEL_TAB[s1_ksel_reg][3*i+0], win2_reg[i])
                       + weigh(KERNEL_TAB[s1_ksel_reg][3*i+1], win1_reg[i])
                       + weigh(KERNEL_TAB[s1_ksel_reg][3*i+2], cur[i]);
        end
        win_sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_ROWS; i++)
            begin
                win1_reg[i] <= '0;
                win2_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < WIN_ROWS; i++)
            begin
                win2_reg[i] <= win1_reg[i];
                win1_reg[i] <= cur[i];
            end
        end
    end

    // ---------------- result queue ----------------
    assign push = s1_valid_reg & (s1_interior_reg | s1_border_reg);

    always_comb
    begin
        push_entry.int_valid = s1_interior_reg;
        push_entry.brd_valid = s1_border_reg;
        push_entry.frame_end = s1_fend_reg;
        push_entry.row       = POS_W'(s1_row_reg);
        push_entry.col       = POS_W'(s1_col_reg);
        push_entry.sum       = win_sum;
        push_entry.px        = s1_px_reg;
    end

    imgconv_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .level      (fifo_level),
        .results    (results)
    );

endmodule

[hw/rtl/imgconv_checker.sv]
// Port-level checks on the result channel of the convolution block, and the
// bind that attaches them to the top level. Depends on imgconv_pkg, imgconv_if.
module imgconv_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    valid,
    input logic                                    ready,
    input logic [imgconv_pkg::POS_W-1:0]           row,
    input logic [imgconv_pkg::POS_W-1:0]           col,
    input logic signed [imgconv_pkg::VALUE_W-1:0]  value,
    input logic                                    from_border,
    input logic                                    frame_end,
    input logic                                    last
);
    import imgconv_pkg::*;

    // a stalled result holds still
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=>
            valid && $stable(row) && $stable(col) && $stable(value) && $stable(last))
        else $error("result changed while stalled");

    // the second result of a pixel is queued with the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last |=> valid && from_border)
        else $error("second result of a pixel missing");

    // frame end only on the final border result
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_end |-> last && from_border)
        else $error("frame end on a non-final result");

    // border results carry a raw pixel
    a_border_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid && from_border |-> value[VALUE_W-1:PIXEL_W] == '0)
        else $error("border value out of pixel range");

endmodule

bind image_3x3_kernel_convolution imgconv_checker u_imgconv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (results.valid),
    .ready       (results.ready),
    .row         (results.row),
    .col         (results.col),
    .value       (results.value),
    .from_border (results.from_border),
    .frame_end   (results.frame_end),
    .last        (results.last)
);

[tb/imgconv_result_checker.sv]
// Result checker for the 3x3 kernel convolution testbench: mirrors register
// writes, predicts the results of every accepted pixel and compares them.
// Depends on imgconv_pkg.
`timescale 1ns / 100ps
module imgconv_result_checker
    import imgconv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    input  logic                      pix_ready,
    input  logic [PIXEL_W-1:0]        pix_data,
    input  logic                      res_valid,
    input  logic                      res_ready,
    input  logic [POS_W-1:0]          res_row,
    input  logic [POS_W-1:0]          res_col,
    input  logic signed [VALUE_W-1:0] res_value,
    input  logic                      res_from_border,
    input  logic                      res_frame_end,
    input  logic                      res_last,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wr_data,
    output int                        mismatch_count,
    output int                        results_owed
);

    typedef struct packed {
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        logic                      from_border;
        logic                      frame_end;
        logic                      last;
    } conv_result_t;

    logic [PIXEL_W-1:0] line_prev  [MAX_WIDTH];
    logic [PIXEL_W-1:0] line_older [MAX_WIDTH];
    // [2*row] holds column c-1, [2*row+1] column c-2
    logic [PIXEL_W-1:0] window_px  [6];
    int                 col_pos;
    int                 row_pos;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [KSEL_W-1:0]  kernel_reg;
    conv_result_t       due_results [$];

    function automatic int clamp_size(input int v, input int maxv);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int                 w;
        int                 h;
        int                 r;
        int                 c;
        int                 sum;
        int                 n_new;
        logic [PIXEL_W-1:0] cur [3];
        conv_result_t       fresh [2];
        conv_result_t       got;
        conv_result_t       want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                line_prev[i]  = '0;
                line_older[i] = '0;
            end
            for (int i = 0; i < 6; i++)
                window_px[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            kernel_reg = '0;
            due_results.delete();
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_wr_data;
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_wr_data;
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    REG_KERNEL_SELECT:
                        kernel_reg = cfg_wr_data[KSEL_W-1:0];
                    default:
                        ;
                endcase
            end

            if (pix_valid && pix_ready)
            begin
                w = clamp_size(int'(width_reg), MAX_WIDTH);
                h = clamp_size(int'(height_reg), MAX_HEIGHT);
                r = row_pos;
                c = col_pos;
                if (c >= w)
                    c = 0;
                if (r >= h)
                    r = 0;
                cur[0] = line_older[c];
                cur[1] = line_prev[c];
                cur[2] = pix_data;
                n_new  = 0;

                // interior result for the pixel one up and one left
                if (r >= 2 && c >= 2)
                begin
                    sum = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum += int'(KERNEL_TAB[kernel_reg][3*i+0]) * int'(window_px[2*i+1]);
                        sum += int'(KERNEL_TAB[kernel_reg][3*i+1]) * int'(window_px[2*i]);
                        sum += int'(KERNEL_TAB[kernel_reg][3*i+2]) * int'(cur[i]);
                    end
                    fresh[n_new] = '{row: POS_W'(r - 1), col: POS_W'(c - 1),
                                     value: VALUE_W'(sum), from_border: 1'b0,
                                     frame_end: 1'b0, last: 1'b0};
                    n_new++;
                end
                // border pixels pass straight through
                if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
                begin
                    fresh[n_new] = '{row: POS_W'(r), col: POS_W'(c),
                                     value: VALUE_W'(pix_data), from_border: 1'b1,
                                     frame_end: 1'b0, last: 1'b0};
                    n_new++;
                end
                if (n_new > 0)
                begin
                    fresh[n_new-1].last      = 1'b1;
                    fresh[n_new-1].frame_end = (r == h - 1 && c == w - 1);
                end
                for (int i = 0; i < n_new; i++)
                    due_results.push_back(fresh[i]);

                line_older[c] = line_prev[c];
                line_prev[c]  = pix_data;
                for (int i = 0; i < 3; i++)
                begin
                    window_px[2*i+1] = window_px[2*i];
                    window_px[2*i]   = cur[i];
                end
                c++;
                if (c >= w)
                begin
                    c = 0;
                    r++;
                    if (r >= h)
                        r = 0;
                end
                col_pos = c;
                row_pos = r;
            end

            if (res_valid && res_ready)
            begin
                got.row         = res_row;
                got.col         = res_col;
                got.value       = res_value;
                got.from_border = res_from_border;
                got.frame_end   = res_frame_end;
                got.last        = res_last;
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result row %0d col %0d value %0d",
                             $time, got.row, got.col, $signed(got.value));
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected row %0d col %0d value %0d ", $time,
                                 want.row, want.col, $signed(want.value),
                                 "border %0b frame_end %0b last %0b; ",
                                 want.from_border, want.frame_end, want.last,
                                 "actual row %0d col %0d value %0d ",
                                 got.row, got.col, $signed(got.value),
                                 "border %0b frame_end %0b last %0b",
                                 got.from_border, got.frame_end, got.last);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            results_owed <= due_results.size();
        end
    end

endmodule

[tb/tb_image_3x3_kernel_convolution.sv]
// Testbench top for the 3x3 kernel convolution block: drives pixels, the
// result ready and register writes; imgconv_result_checker does the checking.
// Depends on imgconv_pkg, imgconv_if and imgconv_result_checker.
`timescale 1ns / 100ps
module tb_image_3x3_kernel_convolution;
    import imgconv_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_PIXELS  = 480;
    // part of the first row of a 1024-wide frame
    localparam int WIDE_PIXELS    = 160;
    // pixel to result passes the read stage and the result queue; leave a margin before touching registers
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    // long output stall, so the result queue fills and pixels back up
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_EVERY     = 400;
    localparam int HOLD_AT        = 100;
    // well above the hold, a drain and a handful of register writes
    localparam int WATCHDOG_LIMIT = 4000;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_NOT_MAPPED = 2'd3;
    // kernels for the directed frame, rows 3..5
    localparam int KERNEL_ORDER [3] = '{2, 3, 1};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    int mismatch_count;
    int results_owed;
    int pixels_sent;
    int random_sent;
    int results_taken;
    int reg_writes;
    int idle_cycles;
    bit pixel_burst;
    bit result_burst;

    imgconv_pixel_if  pixels ();
    imgconv_result_if results ();

    image_3x3_kernel_convolution u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .results     (results),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    imgconv_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix_valid       (pixels.valid),
        .pix_ready       (pixels.ready),
        .pix_data        (pixels.pixel),
        .res_valid       (results.valid),
        .res_ready       (results.ready),
        .res_row         (results.row),
        .res_col         (results.col),
        .res_value       (results.value),
        .res_from_border (results.from_border),
        .res_frame_end   (results.frame_end),
        .res_last        (results.last),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .mismatch_count  (mismatch_count),
        .results_owed    (results_owed)
    );

    always #HALF_PERIOD clk = ~clk;

    // One register write, then a wait with the enable low so that back-to-back writes
    // never lower and raise the enable in the same step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_DATA_W'(data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // Offer one pixel after a random gap (none in burst mode) and hold it
    // until the transaction completes. Valid stays high into the next pixel
    // when no gap is drawn.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        gap = pixel_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            pixels.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.pixel <= px;
        do
            @(posedge clk);
        while (!(pixels.valid && pixels.ready));
        pixels_sent++;
    endtask

    // Close a phase: stop offering, wait for every predicted result, then
    // give the pipeline time to finish pixels that produce no result.
    task automatic drain_results();
        pixels.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly uniform pixels, with the two extremes weighted up
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Result receiver: random ready gaps per transaction, stall-free
    // stretches, and a long hold-off now and then while pixels keep coming.
    initial
    begin : result_receiver
        int gap;
        results.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken % 64 == 0)
                result_burst = ($urandom_range(0, 3) == 0);
            gap = result_burst ? 0 : $urandom_range(0, 3);
            if (results_taken % HOLD_EVERY == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                results.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results.valid && results.ready));
            results_taken++;
        end
    end

    // Watchdog: any cycle without a pixel or result transaction counts
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (pixels.valid && pixels.ready) ||
            (results.valid && results.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int w_data;
        int h_data;
        int fw;
        int fh;
        int count;
        rst_n        = 1'b0;
        pixels.valid = 1'b0;
        pixels.pixel = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        fw           = MIN_SIZE;
        fh           = MIN_SIZE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed frame, 3 wide (written as 0, so clamped) x 6 tall ----
        // Rows 0..2 are 255 | x | 0, giving -765 under kernel 0 at (1,1).
        // Rows 3..5 are all 255. The kernel is switched mid-frame before rows
        // 3, 4 and 5 so that each interior result uses a different kernel; the
        // last one is 1530 under kernel 1. The unmapped index goes in after the
        // size writes so that any aliasing onto them would show.
        cfg_write(REG_IMAGE_WIDTH, 0);
        cfg_write(REG_IMAGE_HEIGHT, 6);
        cfg_write(REG_KERNEL_SELECT, 0);
        cfg_write(REG_NOT_MAPPED, 2047);
        pixel_burst = 1'b1;
        for (int r = 0; r < 6; r++)
        begin
            if (r >= 3)
            begin
                drain_results();
                cfg_write(REG_KERNEL_SELECT, KERNEL_ORDER[r-3]);
            end
            if (r < 3)
            begin
                send_pixel('1);
                send_pixel(PIXEL_W'($urandom_range(1, 254)));
                send_pixel('0);
            end
            else
                repeat (3) send_pixel('1);
        end
        drain_results();

        // ---- Widest rows ----
        // Width 1024 then 2047 (clamped to 1024), height 1024 then 2047
        // (clamped); part of the first row, which must stay all border with
        // no early wrap. The first long hold-off lands in here.
        cfg_write(REG_IMAGE_WIDTH, MAX_WIDTH);
        cfg_write(REG_IMAGE_HEIGHT, MAX_HEIGHT);
        cfg_write(REG_IMAGE_WIDTH, 2047);
        cfg_write(REG_IMAGE_HEIGHT, 2047);
        cfg_write(REG_KERNEL_SELECT, $urandom_range(0, 3));
        pixel_burst = 1'b0;
        repeat (WIDE_PIXELS) send_pixel(pick_pixel());
        drain_results();

        // ---- Random phases on small frames ----
        // Each phase may resize (which restarts the frame, sometimes with
        // sizes below 3 that clamp), may change the kernel, then sends part of
        // a frame, one frame or two. Phases without a resize carry on from
        // wherever the previous one stopped.
        while (random_sent < RANDOM_PIXELS)
        begin
            if (random_sent == 0 || $urandom_range(0, 9) < 7)
            begin
                w_data = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 10);
                h_data = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 6);
                fw = (w_data < MIN_SIZE) ? MIN_SIZE : w_data;
                fh = (h_data < MIN_SIZE) ? MIN_SIZE : h_data;
                if ($urandom_range(0, 1))
                begin
                    cfg_write(REG_IMAGE_WIDTH, w_data);
                    cfg_write(REG_IMAGE_HEIGHT, h_data);
                end
                else
                begin
                    cfg_write(REG_IMAGE_HEIGHT, h_data);
                    cfg_write(REG_IMAGE_WIDTH, w_data);
                end
            end
            if ($urandom_range(0, 1))
                cfg_write(REG_KERNEL_SELECT, $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       count = $urandom_range(1, fw * fh);
                1:       count = 2 * fw * fh;
                default: count = fw * fh;
            endcase
            pixel_burst = ($urandom_range(0, 3) == 0);
            repeat (count)
            begin
                send_pixel(pick_pixel());
                random_sent++;
            end
            drain_results();
        end

        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d pixel transactions (%0d random), %0d result transactions, %0d writes",
                 pixels_sent, random_sent, results_taken, reg_writes);
        $display("over frames 3x3 to 1024 wide, all four kernels, clamped sizes and output stalls");
        if (results_owed != 0)
            $display("%0t: %0d expected results never arrived", $time, results_owed);
        if (mismatch_count == 0 && results_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/imgconv_pkg.sv
hw/rtl/imgconv_if.sv
hw/rtl/imgconv_line_mem.sv
hw/rtl/imgconv_res_fifo.sv
hw/rtl/image_3x3_kernel_convolution.sv
hw/rtl/imgconv_checker.sv
tb/imgconv_result_checker.sv
tb/tb_image_3x3_kernel_convolution.sv
